FILE: src/vertex_transform_4x4_assert.svh
// Assertion macros shared by the vertex transform RTL.
// Needs nothing else; define ASSERT_OFF to compile the checks away.
`ifndef VERTEX_TRANSFORM_4X4_ASSERT_SVH
`define VERTEX_TRANSFORM_4X4_ASSERT_SVH

`ifndef ASSERT_OFF
`define VT_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("vertex transform check failed");
`define VT_ASSERT_NEVER(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("vertex transform forbidden condition seen");
`else
`define VT_ASSERT(lbl, clk, rst_n, prop)
`define VT_ASSERT_NEVER(lbl, clk, rst_n, cond)
`endif

`endif

FILE: src/vt_pkg.sv
// Shared types and constants of the vertex transform unit.
// No dependencies.
package vt_pkg;

  localparam int unsigned FRAC_BITS   = 16;
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned DATA_W      = 32;
  localparam int unsigned IDX_W       = 4;
  localparam int unsigned N_ENTRIES   = 16;

  typedef enum logic {
    OP_LOAD  = 1'b0,
    OP_POINT = 1'b1
  } vt_op_e;

  typedef struct packed {
    vt_op_e              op;
    logic [IDX_W-1:0]    idx;
    logic [DATA_W-1:0]   value;
    logic [DATA_W-1:0]   x;
    logic [DATA_W-1:0]   y;
    logic [DATA_W-1:0]   z;
  } vt_item_t;

  typedef struct packed {
    logic     valid;
    vt_item_t item;
  } vt_issue_t;

endpackage

FILE: src/vertex_transform_4x4.sv
// Vertex transform unit: 4x4 signed fixed-point matrix applied to 3D points.
// Throughput is one item per cycle when the output is not stalled; a load item updates the
// matrix and gives no result. A point's result passes through the issue queue, then the
// multiply stage, the sum stage and the saturating output register.
// Reset is asynchronous and active low: queue and pipeline empty, matrix set to identity.
module vertex_transform_4x4 import vt_pkg::*; #(
  parameter int unsigned FracBits   = FRAC_BITS,
  parameter int unsigned QueueDepth = QUEUE_DEPTH
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic                     kind_i,
  input  logic [IDX_W-1:0]         entry_index_i,
  input  logic signed [DATA_W-1:0] entry_value_i,
  input  logic signed [DATA_W-1:0] point_x_i,
  input  logic signed [DATA_W-1:0] point_y_i,
  input  logic signed [DATA_W-1:0] point_z_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic signed [DATA_W-1:0] out_x_o,
  output logic signed [DATA_W-1:0] out_y_o,
  output logic signed [DATA_W-1:0] out_z_o,
  output logic signed [DATA_W-1:0] out_w_o,
  output logic                     saturated_o
);

  vt_issue_t issue;
  logic      issue_ready;

  vt_front #(
    .QueueDepth(QueueDepth)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .kind_i        (kind_i),
    .entry_index_i (entry_index_i),
    .entry_value_i (entry_value_i),
    .point_x_i     (point_x_i),
    .point_y_i     (point_y_i),
    .point_z_i     (point_z_i),
    .issue_o       (issue),
    .issue_ready_i (issue_ready)
  );

  vt_back #(
    .FracBits(FracBits)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .issue_i       (issue),
    .issue_ready_o (issue_ready),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .out_x_o       (out_x_o),
    .out_y_o       (out_y_o),
    .out_z_o       (out_z_o),
    .out_w_o       (out_w_o),
    .saturated_o   (saturated_o)
  );

endmodule

FILE: src/vt_front.sv
// Front end of the vertex transform unit: takes items, decodes their kind
// and holds them in a short in-order queue. Depends on vt_pkg.
`include "vertex_transform_4x4_assert.svh"

module vt_front import vt_pkg::*; #(
  parameter int unsigned QueueDepth = QUEUE_DEPTH
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic                     kind_i,
  input  logic [IDX_W-1:0]         entry_index_i,
  input  logic signed [DATA_W-1:0] entry_value_i,
  input  logic signed [DATA_W-1:0] point_x_i,
  input  logic signed [DATA_W-1:0] point_y_i,
  input  logic signed [DATA_W-1:0] point_z_i,
  output vt_issue_t                issue_o,
  input  logic                     issue_ready_i
);

  localparam int unsigned PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned CntW = $clog2(QueueDepth + 1);

  vt_item_t          q_mem [QueueDepth];
  logic [PtrW-1:0]   wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic              push, pop;
  vt_item_t          new_item;

  always_comb begin
    new_item.op    = vt_op_e'(kind_i);
    new_item.idx   = entry_index_i;
    new_item.value = entry_value_i;
    new_item.x     = point_x_i;
    new_item.y     = point_y_i;
    new_item.z     = point_z_i;
  end

  assign in_ready_o    = (cnt_q != CntW'(QueueDepth));
  assign push          = in_valid_i && in_ready_o;
  assign issue_o.valid = (cnt_q != '0);
  assign issue_o.item  = q_mem[rd_ptr_q];
  assign pop           = issue_o.valid && issue_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Queue storage is payload only and needs no reset.
  always_ff @(posedge clk_i) begin
    if (push) begin
      q_mem[wr_ptr_q] <= new_item;
    end
  end

  `VT_ASSERT_NEVER(a_cnt_in_range, clk_i, rst_ni, cnt_q > CntW'(QueueDepth))
  `VT_ASSERT(a_pop_drains, clk_i, rst_ni, (pop && !push) |=> cnt_q == $past(cnt_q) - 1'b1)
  `VT_ASSERT(a_issue_hold, clk_i, rst_ni,
             (issue_o.valid && !issue_ready_i) |=> issue_o.valid && $stable(issue_o.item))

endmodule

FILE: src/vt_back.sv
// Back end of the vertex transform unit: the matrix registers and the
// multiply, sum and saturate pipeline. Depends on vt_pkg.
`include "vertex_transform_4x4_assert.svh"

module vt_back import vt_pkg::*; #(
  parameter int unsigned FracBits = FRAC_BITS
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  vt_issue_t                issue_i,
  output logic                     issue_ready_o,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic signed [DATA_W-1:0] out_x_o,
  output logic signed [DATA_W-1:0] out_y_o,
  output logic signed [DATA_W-1:0] out_z_o,
  output logic signed [DATA_W-1:0] out_w_o,
  output logic                     saturated_o
);

  localparam int unsigned ProdW = 2 * DATA_W;
  localparam int unsigned TermW = ProdW - FracBits;
  localparam int unsigned SumW  = TermW + 2;
  localparam logic [DATA_W-1:0] One = DATA_W'(1) << FracBits;

  logic [DATA_W-1:0]       mat_q [N_ENTRIES];
  logic signed [ProdW-1:0] prod_q [4][3];
  logic signed [DATA_W-1:0] trans_q [4];
  logic signed [SumW-1:0]  sum_q [4];
  logic signed [DATA_W-1:0] res_q [4];
  logic                    sat_q;
  logic                    v1_q, v2_q, v3_q;
  logic                    rdy1, rdy2, rdy3;
  logic                    pop, is_load, take_point;
  logic signed [DATA_W-1:0] pt [3];
  logic signed [SumW-1:0]  sum_d [4];
  logic signed [DATA_W-1:0] res_d [4];
  logic [3:0]              clip;

  assign rdy3 = !v3_q || out_ready_i;
  assign rdy2 = !v2_q || rdy3;
  assign rdy1 = !v1_q || rdy2;

  // A load needs no pipeline slot, so it leaves the queue at once.
  assign is_load       = (issue_i.item.op == OP_LOAD);
  assign issue_ready_o = is_load || rdy1;
  assign pop           = issue_i.valid && issue_ready_o;
  assign take_point    = pop && !is_load;

  assign pt[0] = issue_i.item.x;
  assign pt[1] = issue_i.item.y;
  assign pt[2] = issue_i.item.z;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < N_ENTRIES; i++) begin
        mat_q[i] <= ((i / 4) == (i % 4)) ? One : '0;
      end
    end else if (pop && is_load) begin
      mat_q[issue_i.item.idx] <= issue_i.item.value;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= take_point;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
    end
  end

  // Stage one: twelve products at full width.
  always_ff @(posedge clk_i) begin
    if (take_point && rdy1) begin
      for (int r = 0; r < 4; r++) begin
        for (int c = 0; c < 3; c++) begin
          prod_q[r][c] <= ProdW'($signed(mat_q[r * 4 + c])) * ProdW'(pt[c]);
        end
        trans_q[r] <= $signed(mat_q[r * 4 + 3]);
      end
    end
  end

  // Stage two: drop the fraction bits (a floor, as the products are signed)
  // and add the row terms at full width.
  always_comb begin
    for (int r = 0; r < 4; r++) begin
      sum_d[r] = SumW'(trans_q[r]);
      for (int c = 0; c < 3; c++) begin
        sum_d[r] = sum_d[r] + SumW'($signed(prod_q[r][c][ProdW-1:FracBits]));
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (v1_q && rdy2) begin
      for (int r = 0; r < 4; r++) begin
        sum_q[r] <= sum_d[r];
      end
    end
  end

  // Stage three: clip each sum to 32 bits.
  always_comb begin
    for (int r = 0; r < 4; r++) begin
      clip[r]  = !((&sum_q[r][SumW-1:DATA_W-1]) || !(|sum_q[r][SumW-1:DATA_W-1]));
      if (!clip[r]) begin
        res_d[r] = sum_q[r][DATA_W-1:0];
      end else if (sum_q[r][SumW-1]) begin
        res_d[r] = {1'b1, {(DATA_W-1){1'b0}}};
      end else begin
        res_d[r] = {1'b0, {(DATA_W-1){1'b1}}};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (v2_q && rdy3) begin
      for (int r = 0; r < 4; r++) begin
        res_q[r] <= res_d[r];
      end
      sat_q <= |clip;
    end
  end

  assign out_valid_o = v3_q;
  assign out_x_o     = res_q[0];
  assign out_y_o     = res_q[1];
  assign out_z_o     = res_q[2];
  assign out_w_o     = res_q[3];
  assign saturated_o = sat_q;

  `VT_ASSERT(a_load_written, clk_i, rst_ni,
             (pop && is_load) |=> mat_q[$past(issue_i.item.idx)] == $past(issue_i.item.value))
  `VT_ASSERT(a_s1_hold, clk_i, rst_ni,
             (v1_q && !rdy2) |=> v1_q && $stable(trans_q[0]) && $stable(prod_q[0][0]))
  `VT_ASSERT(a_out_hold, clk_i, rst_ni,
             (out_valid_o && !out_ready_i) |=> out_valid_o && $stable(out_x_o) && $stable(saturated_o))

endmodule
